/* rtl/trigram_count_min_sketch_assert.svh */
// Assertion macros shared by the RTL of the trigram count-min sketch.
`ifndef TRIGRAM_COUNT_MIN_SKETCH_ASSERT_SVH
`define TRIGRAM_COUNT_MIN_SKETCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trigram_count_min_sketch: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trigram_count_min_sketch: next-cycle check failed");

`endif

/* rtl/tcms_pkg.sv */
`timescale 1ns / 1ps
package tcms_pkg;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_EST   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_RUN   = 2'd2
   } state_type;

   localparam logic [30:0] COUNT_MAX = 31'h7fffffff;
   localparam logic [31:0] MIX_A     = 32'h7feb352d;
   localparam logic [31:0] MIX_B     = 32'h846ca68b;

   // Row whose column is on the broadcast bus this cycle.
   typedef struct packed {
      logic       valid;
      logic [2:0] row;
   } probe_type;

   // Request state handed from cell to cell along the chain.
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] amount;
      logic [2:0]  rsel;
      logic        hit;
      logic [30:0] acc;
   } token_type;

endpackage

/* rtl/tcms_hash.sv */
`timescale 1ns / 1ps
module tcms_hash #(
   parameter int CW = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue_valid,
   input  logic [2:0]          issue_row,
   input  logic [23:0]         key,
   input  logic                use_csel,
   input  logic [4:0]          csel,
   output tcms_pkg::probe_type probe,
   output logic [CW-1:0]       col
);
   import tcms_pkg::*;

   probe_type   pa_ff, pb_ff, pc_ff;
   logic [31:0] seed;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [31:0] b_mix, hash;

   always_comb begin
      seed  = {5'b0, issue_row, key};
      a_in  = seed ^ (seed >> 16);
      b_in  = a_ff * MIX_A;
      b_mix = b_ff ^ (b_ff >> 15);
      c_in  = b_mix * MIX_B;
      hash  = c_ff ^ (c_ff >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff <= '0;
         pb_ff <= '0;
         pc_ff <= '0;
      end else begin
         pa_ff <= '{valid: issue_valid, row: issue_row};
         pb_ff <= pa_ff;
         pc_ff <= pb_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
   end

   assign probe = pc_ff;
   assign col   = use_csel ? CW'(csel) : hash[CW-1:0];

endmodule

/* rtl/tcms_cell.sv */
`timescale 1ns / 1ps
module tcms_cell #(
   parameter int INDEX   = 0,
   parameter int COLUMNS = 32,
   parameter int CW      = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  tcms_pkg::probe_type probe,
   input  logic [CW-1:0]       col,
   input  logic                wipe_en,
   input  logic [CW-1:0]       wipe_addr,
   input  tcms_pkg::token_type tok_i,
   output tcms_pkg::token_type tok_o
);
   import tcms_pkg::*;

   logic [30:0]   mem [COLUMNS];
   logic [30:0]   rdata_ff;
   logic [CW-1:0] col_ff;
   token_type     tok_ff;
   logic          probe_hit;
   logic          wr_en;
   logic [31:0]   sum;
   logic [30:0]   wdata;

   assign probe_hit = probe.valid && (probe.row == 3'(INDEX));

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      if (probe_hit) begin
         rdata_ff <= mem[col];
         col_ff   <= col;
      end
      if (wipe_en) begin
         mem[wipe_addr] <= '0;
      end else if (wr_en) begin
         mem[col_ff] <= wdata;
      end
   end

   always_comb begin
      sum   = {1'b0, rdata_ff} + {16'b0, tok_ff.amount};
      wdata = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[30:0];
      wr_en = tok_ff.valid && (tok_ff.kind == KIND_ADD);
      tok_o = tok_ff;
      case (tok_ff.kind)
         KIND_EST: begin
            if (rdata_ff < tok_ff.acc) begin
               tok_o.acc = rdata_ff;
            end
         end
         KIND_READ: begin
            if (tok_ff.hit && (tok_ff.rsel == 3'(INDEX))) begin
               tok_o.acc = rdata_ff;
            end
         end
         default: begin
            tok_o.acc = tok_ff.acc;
         end
      endcase
   end

endmodule

/* rtl/trigram_count_min_sketch.sv */
`timescale 1ns / 1ps
// Count-min sketch over 24-bit trigram keys, ROWS rows of COLUMNS saturating
// 31-bit counters. Requests arrive on the req_ channel (valid and stall) and
// carry a kind: add, estimate, read one counter or clear all counters.
// Estimate and read each return one result on the rsp_ channel; add and
// clear return nothing.
// A shared hash pipeline issues one row per cycle and broadcasts its column
// to a chain of cells, one cell per row, each owning that row's counters.
// The request walks the chain one cell per cycle, updating or taking the
// minimum as it passes. One request is in flight at a time: its result is
// registered onto rsp_valid after it leaves the last cell, and the next add,
// estimate or read is taken only once the request has left the chain.
// Clear keeps req_stall high while every cell zeroes one column per cycle,
// sweeping all COLUMNS columns. After reset the same clearing pass runs with
// req_stall high. A result that meets rsp_stall waits in the output register
// with a spare register behind it, so the next request is still taken; a
// further request is held off only while that spare is occupied.
module trigram_count_min_sketch #(
   parameter int ROWS    = 6,
   parameter int COLUMNS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [23:0] req_trigram,
   input  logic [15:0] req_amount,
   input  logic [2:0]  req_row_select,
   input  logic [4:0]  req_column_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_value
);
   import tcms_pkg::*;

`include "trigram_count_min_sketch_assert.svh"

   localparam int CW = $clog2(COLUMNS);
   localparam int IW = $clog2(ROWS + 1);

   state_type     state_ff, state_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic [CW-1:0] wipe_ff, wipe_in;
   logic          wipe_en;
   logic          issue_valid;
   logic          accept;
   logic          clear_accept;

   kind_type      kind_ff;
   logic [23:0]   key_ff;
   logic [15:0]   amount_ff;
   logic [2:0]    rsel_ff;
   logic [4:0]    csel_ff;
   logic          hit_ff;

   probe_type     probe;
   logic [CW-1:0] col;
   token_type     chain [ROWS+1];

   logic          res_valid;
   logic          out_take;
   logic          out_valid_ff, out_valid_in;
   logic [30:0]   out_value_ff, out_value_in;
   logic          hold_valid_ff, hold_valid_in;
   logic [30:0]   hold_value_ff, hold_value_in;

   assign req_stall    = (state_ff != ST_IDLE) || hold_valid_ff;
   assign accept       = req_valid && !req_stall;
   assign clear_accept = accept && (req_kind == KIND_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         issue_ff <= '0;
         wipe_ff  <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         wipe_ff  <= wipe_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      wipe_in     = wipe_ff;
      wipe_en     = 1'b0;
      issue_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_CLEAR) begin
                  state_in = ST_CLEAR;
                  wipe_in  = '0;
               end else begin
                  state_in = ST_RUN;
                  issue_in = '0;
               end
            end
         end
         ST_RUN: begin
            issue_valid = (issue_ff < IW'(ROWS));
            if (issue_valid) begin
               issue_in = issue_ff + 1'b1;
            end
            if (chain[ROWS].valid) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wipe_en = 1'b1;
            wipe_in = wipe_ff + 1'b1;
            if (wipe_ff == CW'(COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         key_ff    <= req_trigram;
         amount_ff <= req_amount;
         rsel_ff   <= req_row_select;
         csel_ff   <= req_column_select;
         hit_ff    <= ({27'b0, req_column_select} < 32'(COLUMNS))
                      && ({29'b0, req_row_select} < 32'(ROWS));
      end
   end

   tcms_hash #(.CW(CW)) u_hash (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_row   (3'(issue_ff)),
      .key         (key_ff),
      .use_csel    (kind_ff == KIND_READ),
      .csel        (csel_ff),
      .probe       (probe),
      .col         (col)
   );

   always_comb begin
      chain[0].valid  = probe.valid && (probe.row == 3'd0);
      chain[0].kind   = kind_ff;
      chain[0].amount = amount_ff;
      chain[0].rsel   = rsel_ff;
      chain[0].hit    = hit_ff;
      chain[0].acc    = (kind_ff == KIND_EST) ? COUNT_MAX : '0;
   end

   for (genvar i = 0; i < ROWS; i++) begin : g_cell
      tcms_cell #(.INDEX(i), .COLUMNS(COLUMNS), .CW(CW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe     (probe),
         .col       (col),
         .wipe_en   (wipe_en),
         .wipe_addr (wipe_ff),
         .tok_i     (chain[i]),
         .tok_o     (chain[i+1])
      );
   end

   assign res_valid = chain[ROWS].valid && (chain[ROWS].kind inside {KIND_EST, KIND_READ});
   assign out_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      if (hold_valid_ff) begin
         if (out_take) begin
            out_value_in  = hold_value_ff;
            hold_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_value_in = chain[ROWS].acc;
         end else begin
            hold_valid_in = 1'b1;
            hold_value_in = chain[ROWS].acc;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      hold_value_ff <= hold_value_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

   `TCMS_ASSERT_SAME(a_hold_behind_out, clock, reset, hold_valid_ff, out_valid_ff)
   `TCMS_ASSERT_SAME(a_chain_only_in_run, clock, reset, chain[ROWS].valid, state_ff == ST_RUN)
   `TCMS_ASSERT_SAME(a_probe_only_in_run, clock, reset, probe.valid, state_ff == ST_RUN)
   `TCMS_ASSERT_NEXT(a_clear_starts_sweep, clock, reset, clear_accept, wipe_en && (wipe_ff == '0))

endmodule
